// ===== src/length_prefixed_frame_receiver_macros.svh =====
// Assertion macros for the frame receiver.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTH

`define LPFR_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

`define LPFR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`else

`define LPFR_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)

`define LPFR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== src/lpfr_pkg.sv =====
package lpfr_pkg;

	localparam int MAX_PAYLOAD = 256;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = CFG_IDX_W'(1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_RESET = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_TAKEN   = 3'd1;
	localparam logic [2:0] ST_DONE    = 3'd2;
	localparam logic [2:0] ST_BADLEN  = 3'd3;
	localparam logic [2:0] ST_LONG    = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;
	localparam logic [2:0] ST_READ    = 3'd6;

	localparam logic [7:0] CH_OPEN = 8'h3C;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HDR,
		PH_LEN1,
		PH_DATA
	} phase_t;

endpackage

// ===== src/lpfr_if.sv =====
interface lpfr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, output action, output rx_byte, output read_index, input ready);
	modport sink (input valid, input action, input rx_byte, input read_index, output ready);
endinterface

interface lpfr_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [8:0] frame_length;
	logic [7:0] read_data;
	logic       busy_res;

	modport source (output valid, output status, output frame_length, output read_data,
		output busy_res, input ready);
	modport sink (input valid, input status, input frame_length, input read_data,
		input busy_res, output ready);
endinterface

interface lpfr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lpfr_pkg::CFG_IDX_W-1:0]  index;
	logic [lpfr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/length_prefixed_frame_receiver.sv =====
// Channel  Role    Beat contents
// -------  ------  ----------------------------------------------
// req      sink    action, rx_byte, read_index
// rsp      source  status, frame_length, read_data, busy_res
// cfg      sink    index (0 line_mode, 1 timeout_ticks), data
//
// One beat per cycle in and out while rsp is not stalled; a result is held
// in s1 for the payload RAM read and then in the output register.
// Parser state sits in flops, payload bytes in a one-port-write RAM.
// arst_n resets parser, config and valid flags; RAM contents are undefined.
// A stalled rsp still lets one more beat into s1; cfg is always ready.

`include "length_prefixed_frame_receiver_macros.svh"

module length_prefixed_frame_receiver #(
	parameter int MaxPayload = lpfr_pkg::MAX_PAYLOAD
) (
	input  logic       clk,
	input  logic       arst_n,
	lpfr_req_if.sink   req,
	lpfr_rsp_if.source rsp,
	lpfr_cfg_if.sink   cfg
);
	import lpfr_pkg::*;

	localparam int AW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
	localparam int CW = $clog2(MaxPayload + 1);
	localparam int IW = ((AW > 8) ? AW : 8) + 1;
	localparam logic [15:0] MAX16 = 16'(MaxPayload);

	logic          line_mode_q;
	logic [15:0]   timeout_q;
	phase_t        phase_q, phase_d;
	logic [15:0]   exp_q, exp_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [15:0]   ticks_q, ticks_d;

	logic          accept;
	logic [2:0]    st_d;
	logic [8:0]    flen_d;
	logic          busy_d;
	logic          wr_en;
	logic          rd_en;
	logic          rd_oob;
	logic [AW-1:0] rd_addr;
	logic [IW-1:0] idx_wide;
	logic [15:0]   cnt16;
	logic [15:0]   cnt_inc16;
	logic [15:0]   len_full;
	logic [15:0]   ticks_inc;
	logic [7:0]    ram_rdata;
	logic          cfg_mode_wr;
	logic          cfg_clear;

	logic          s1_valid;
	logic [2:0]    status_s1;
	logic [8:0]    flen_s1;
	logic          busy_s1;
	logic          oob_s1;
	logic          s1_adv;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [8:0]    flen_q;
	logic [7:0]    rdata_q;
	logic          busy_q;

	logic          rsp_final;
	logic          exp_in_range;

	assign accept    = req.valid && req.ready;
	assign s1_adv    = !out_valid_q || rsp.ready;
	assign req.ready = !s1_valid || s1_adv;
	assign cfg.ready = 1'b1;

	assign cfg_mode_wr = cfg.valid && (cfg.index == CFG_LINE_MODE);
	assign cfg_clear   = cfg_mode_wr && (cfg.data[0] != line_mode_q);

	assign cnt16     = 16'(cnt_q);
	assign cnt_inc16 = cnt16 + 16'd1;
	assign len_full  = {req.rx_byte, exp_q[7:0]};
	assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign idx_wide  = IW'(req.read_index);
	assign rd_addr   = idx_wide[AW-1:0];
	assign rd_oob    = idx_wide >= IW'(MaxPayload);

	always_comb begin
		phase_d = phase_q;
		exp_d   = exp_q;
		cnt_d   = cnt_q;
		ticks_d = ticks_q;
		st_d    = ST_NONE;
		flen_d  = 9'd0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		case (req.action)
			ACT_BYTE: begin
				if (line_mode_q) begin
					if (req.rx_byte == CH_CR || req.rx_byte == CH_LF) begin
						if (cnt_q != '0) begin
							flen_d  = cnt16[8:0];
							st_d    = ST_DONE;
							phase_d = PH_IDLE;
							exp_d   = '0;
							cnt_d   = '0;
							ticks_d = '0;
						end
					end else if (cnt16 < MAX16) begin
						if (cnt_q == '0) begin
							ticks_d = '0;
						end
						wr_en = 1'b1;
						cnt_d = cnt_inc16[CW-1:0];
						st_d  = ST_TAKEN;
					end else begin
						st_d    = ST_LONG;
						phase_d = PH_IDLE;
						exp_d   = '0;
						cnt_d   = '0;
						ticks_d = '0;
					end
				end else begin
					case (phase_q)
						PH_IDLE: begin
							if (req.rx_byte == CH_OPEN) begin
								phase_d = PH_HDR;
								ticks_d = '0;
								st_d    = ST_TAKEN;
							end
						end
						PH_HDR: begin
							exp_d   = 16'(req.rx_byte);
							phase_d = PH_LEN1;
							st_d    = ST_TAKEN;
						end
						PH_LEN1: begin
							if (len_full == 16'd0 || len_full > MAX16) begin
								st_d    = ST_BADLEN;
								phase_d = PH_IDLE;
								exp_d   = '0;
								cnt_d   = '0;
								ticks_d = '0;
							end else begin
								exp_d   = len_full;
								cnt_d   = '0;
								phase_d = PH_DATA;
								st_d    = ST_TAKEN;
							end
						end
						default: begin
							wr_en = cnt16 < MAX16;
							if (cnt_inc16 >= exp_q) begin
								flen_d  = exp_q[8:0];
								st_d    = ST_DONE;
								phase_d = PH_IDLE;
								exp_d   = '0;
								cnt_d   = '0;
								ticks_d = '0;
							end else begin
								cnt_d = cnt_inc16[CW-1:0];
								st_d  = ST_TAKEN;
							end
						end
					endcase
				end
			end
			ACT_TICK: begin
				if (!line_mode_q && (phase_q != PH_IDLE || cnt_q != '0)) begin
					if (ticks_inc >= timeout_q) begin
						st_d    = ST_TIMEOUT;
						phase_d = PH_IDLE;
						exp_d   = '0;
						cnt_d   = '0;
						ticks_d = '0;
					end else begin
						ticks_d = ticks_inc;
					end
				end
			end
			ACT_RESET: begin
				phase_d = PH_IDLE;
				exp_d   = '0;
				cnt_d   = '0;
				ticks_d = '0;
			end
			default: begin
				rd_en = 1'b1;
				st_d  = ST_READ;
			end
		endcase
		busy_d = (phase_d != PH_IDLE) || (cnt_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_LINE_MODE) begin
				line_mode_q <= cfg.data[0];
			end else if (cfg.index == CFG_TIMEOUT) begin
				timeout_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			exp_q   <= '0;
			cnt_q   <= '0;
			ticks_q <= '0;
		end else if (cfg_clear) begin
			phase_q <= PH_IDLE;
			exp_q   <= '0;
			cnt_q   <= '0;
			ticks_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			exp_q   <= exp_d;
			cnt_q   <= cnt_d;
			ticks_q <= ticks_d;
		end
	end

	lpfr_ram #(
		.Width (8),
		.Depth (MaxPayload)
	) u_payload (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (req.rx_byte),
		.re    (accept && rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req.ready) begin
			s1_valid <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_d;
			flen_s1   <= flen_d;
			busy_s1   <= busy_d;
			oob_s1    <= rd_oob;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid) begin
			status_q <= status_s1;
			flen_q   <= flen_s1;
			busy_q   <= busy_s1;
			rdata_q  <= (status_s1 == ST_READ && !oob_s1) ? ram_rdata : 8'd0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.frame_length = flen_q;
	assign rsp.read_data    = rdata_q;
	assign rsp.busy_res     = busy_q;

	assign rsp_final    = out_valid_q &&
		(status_q inside {ST_DONE, ST_BADLEN, ST_LONG, ST_TIMEOUT});
	assign exp_in_range = exp_q != 16'd0 && exp_q <= MAX16 && cnt16 < exp_q;

	`LPFR_ASSERT_IMPLY(a_end_not_busy, clk, arst_n, rsp_final, !busy_q)
	`LPFR_ASSERT_IMPLY(a_flen_only_done, clk, arst_n, out_valid_q && status_q != ST_DONE, flen_q == 9'd0)
	`LPFR_ASSERT_IMPLY(a_data_len_ok, clk, arst_n, phase_q == PH_DATA, exp_in_range)
	`LPFR_ASSERT_IMPLY(a_no_overrun, clk, arst_n, s1_valid && !s1_adv, !accept)

endmodule

// ===== src/lpfr_ram.sv =====
module lpfr_ram #(
	parameter int Width = 8,
	parameter int Depth = lpfr_pkg::MAX_PAYLOAD,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== bench/tb_length_prefixed_frame_receiver.sv =====
`timescale 1ns / 100ps

module tb_length_prefixed_frame_receiver;
	import lpfr_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} rx_event_t;

	typedef struct packed {
		logic [2:0] status;
		logic [8:0] frame_length;
		logic [7:0] read_data;
		logic       busy;
	} result_t;

	class deframer_scoreboard;
		bit          line_mode;
		logic [15:0] timeout_ticks;
		phase_t      parse_ph;
		logic [15:0] exp_len;
		logic [8:0]  rcv_cnt;
		logic [15:0] elapsed;
		logic [7:0]  payload [MAX_PAYLOAD];
		int          filled;
		result_t     pending_results [$];
		int          failures;

		function new();
			line_mode = 1'b0;
			timeout_ticks = TIMEOUT_RESET;
			filled = 0;
			failures = 0;
			clear_parser();
		endfunction

		function void clear_parser();
			parse_ph = PH_IDLE;
			exp_len = '0;
			rcv_cnt = '0;
			elapsed = '0;
		endfunction

		function bit parser_busy();
			return parse_ph != PH_IDLE || rcv_cnt != 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void store_byte(logic [7:0] c);
			payload[rcv_cnt[7:0]] = c;
			if (int'(rcv_cnt) >= filled) begin
				filled = int'(rcv_cnt) + 1;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LINE_MODE: begin
					if (data[0] != line_mode) begin
						clear_parser();
					end
					line_mode = data[0];
				end
				CFG_TIMEOUT: begin
					timeout_ticks = data;
				end
				default: ;
			endcase
		endfunction

		function void absorb_event(rx_event_t ev);
			result_t     r;
			logic [7:0]  c;
			r = '0;
			c = ev.rx_byte;
			case (ev.action)
				ACT_BYTE: begin
					if (line_mode) begin
						if (c == CH_CR || c == CH_LF) begin
							if (rcv_cnt != 0) begin
								r.frame_length = rcv_cnt;
								r.status = ST_DONE;
								clear_parser();
							end
						end else if (rcv_cnt < MAX_PAYLOAD) begin
							if (rcv_cnt == 0) begin
								elapsed = '0;
							end
							store_byte(c);
							rcv_cnt = rcv_cnt + 9'd1;
							r.status = ST_TAKEN;
						end else begin
							clear_parser();
							r.status = ST_LONG;
						end
					end else begin
						case (parse_ph)
							PH_IDLE: begin
								if (c == CH_OPEN) begin
									parse_ph = PH_HDR;
									elapsed = '0;
									r.status = ST_TAKEN;
								end
							end
							PH_HDR: begin
								exp_len = {8'd0, c};
								parse_ph = PH_LEN1;
								r.status = ST_TAKEN;
							end
							PH_LEN1: begin
								exp_len[15:8] = c;
								if (exp_len == 16'd0 || exp_len > 16'(MAX_PAYLOAD)) begin
									clear_parser();
									r.status = ST_BADLEN;
								end else begin
									rcv_cnt = '0;
									parse_ph = PH_DATA;
									r.status = ST_TAKEN;
								end
							end
							default: begin
								if (rcv_cnt < MAX_PAYLOAD) begin
									store_byte(c);
								end
								rcv_cnt = rcv_cnt + 9'd1;
								if ({7'd0, rcv_cnt} >= exp_len) begin
									r.frame_length = exp_len[8:0];
									r.status = ST_DONE;
									clear_parser();
								end else begin
									r.status = ST_TAKEN;
								end
							end
						endcase
					end
				end
				ACT_TICK: begin
					if (!line_mode && parser_busy()) begin
						if (elapsed != 16'hFFFF) begin
							elapsed = elapsed + 16'd1;
						end
						if (elapsed >= timeout_ticks) begin
							clear_parser();
							r.status = ST_TIMEOUT;
						end
					end
				end
				ACT_RESET: begin
					clear_parser();
				end
				default: begin
					if (int'(ev.read_index) < MAX_PAYLOAD) begin
						r.read_data = payload[ev.read_index];
					end
					r.status = ST_READ;
				end
			endcase
			r.busy = parser_busy();
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected result: status %0d len %0d data %02h busy %0b",
						got.status, got.frame_length, got.read_data, got.busy);
				end
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.frame_length !== want.frame_length ||
					got.read_data !== want.read_data || got.busy !== want.busy) begin
				failures++;
				if (failures <= 10) begin
					$display("result mismatch: expected status %0d len %0d data %02h busy %0b",
						want.status, want.frame_length, want.read_data, want.busy);
					$display("                 actual   status %0d len %0d data %02h busy %0b",
						got.status, got.frame_length, got.read_data, got.busy);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	lpfr_req_if req_bus();
	lpfr_rsp_if rsp_bus();
	lpfr_cfg_if cfg_bus();

	length_prefixed_frame_receiver i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	deframer_scoreboard sb = new();

	bit src_calm;
	bit sink_calm;
	int beats_sent;
	int cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(input logic [1:0] act, input logic [7:0] c, input logic [7:0] idx);
		rx_event_t ev;
		int        gap;
		ev.action = act;
		ev.rx_byte = c;
		ev.read_index = idx;
		gap = src_calm ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 39) == 0) begin
			src_calm = !src_calm;
		end
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.action <= act;
		req_bus.rx_byte <= c;
		req_bus.read_index <= idx;
		do @(posedge clk); while (!req_bus.ready);
		sb.absorb_event(ev);
		beats_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		send(ACT_BYTE, c, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_tick();
		send(ACT_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_restart();
		send(ACT_RESET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_read_at(input logic [7:0] idx);
		send(ACT_READ, 8'($urandom_range(0, 255)), idx);
	endtask

	// only entries already written are read back
	task automatic send_read_any();
		if (sb.filled > 0) begin
			send_read_at(8'($urandom_range(0, sb.filled - 1)));
		end
	endtask

	task automatic send_header(input logic [15:0] len);
		send_byte(CH_OPEN);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
		return c;
	endfunction

	function automatic int short_len();
		return ($urandom_range(0, 11) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
	endfunction

	task automatic send_frame(input logic [15:0] len, input bit noisy);
		send_byte(CH_OPEN);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 0; i < int'(len); i++) begin
			if (noisy && $urandom_range(0, 9) == 0) begin
				send_tick();
			end
			if (noisy && $urandom_range(0, 24) == 0) begin
				send_read_any();
			end
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_line(input int len, input bit terminate, input bit noisy);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 11) == 0) begin
				send_tick();
			end
			if (noisy && $urandom_range(0, 29) == 0) begin
				send_read_any();
			end
			send_byte(text_byte());
		end
		if (terminate) begin
			send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
		end
	endtask

	task automatic framed_traffic(input int n);
		int stop;
		int pick;
		int len;
		stop = beats_sent + n;
		while (beats_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_frame(16'(short_len()), 1'b1);
			end else if (pick < 65) begin
				case ($urandom_range(0, 2))
					0: len = 0;
					1: len = $urandom_range(MAX_PAYLOAD + 1, 65535);
					default: len = 65535;
				endcase
				send_byte(CH_OPEN);
				send_byte(8'(len));
				send_byte(8'(len >> 8));
			end else if (pick < 73) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 81) begin
				send_read_any();
			end else if (pick < 88) begin
				send_byte(CH_OPEN);
				if ($urandom_range(0, 1)) begin
					send_byte(8'($urandom_range(1, 255)));
					send_byte(8'd0);
					repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
				end
				send_restart();
			end else begin
				// frame in progress, then a run of ticks
				send_byte(CH_OPEN);
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(2, 40)));
				repeat ($urandom_range(1, 4)) send_tick();
			end
		end
	endtask

	task automatic line_traffic(input int n);
		int stop;
		int pick;
		stop = beats_sent + n;
		while (beats_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_line(short_len(), 1'b1, 1'b1);
			end else if (pick < 65) begin
				send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
			end else if (pick < 73) begin
				send_read_any();
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 3)) send_tick();
			end else if (pick < 88) begin
				send_line($urandom_range(1, 6), 1'b0, 1'b0);
				send_restart();
			end else begin
				send_byte(CH_OPEN);
				send_line($urandom_range(0, 4), 1'b1, 1'b0);
			end
		end
	endtask

	// sometimes a phase ends with a frame or line half received
	task automatic leave_partial();
		if ($urandom_range(0, 1)) begin
			if (sb.line_mode) begin
				send_byte(text_byte());
			end else begin
				send_byte(CH_OPEN);
			end
		end
	endtask

	task automatic settle();
		req_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input bit mode, input logic [15:0] tmo);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= CFG_LINE_MODE;
		cfg_bus.data <= {15'd0, mode};
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_reg(CFG_LINE_MODE, {15'd0, mode});
		cfg_bus.index <= CFG_TIMEOUT;
		cfg_bus.data <= tmo;
		do @(posedge clk); while (!cfg_bus.ready);
		sb.write_reg(CFG_TIMEOUT, tmo);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin : result_sink
		int      gap;
		int      got;
		result_t r;
		got = 0;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = sink_calm ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 39) == 0) begin
				sink_calm = !sink_calm;
			end
			// long hold-off so the block backs up and stalls its input
			if (got == 150 || got == 400) begin
				gap = 240;
			end
			if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			r.status = rsp_bus.status;
			r.frame_length = rsp_bus.frame_length;
			r.read_data = rsp_bus.read_data;
			r.busy = rsp_bus.busy_res;
			sb.check_result(r);
			got++;
		end
	end

	initial begin
		beats_sent = 0;
		src_calm = 1'b0;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.action <= ACT_TICK;
		req_bus.rx_byte <= '0;
		req_bus.read_index <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= CFG_LINE_MODE;
		cfg_bus.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// framed mode, reset timeout
		send_byte(8'h00);
		send_byte(8'hFF);
		send_tick();
		send_restart();
		send_header(16'd0);
		send_header(16'd257);
		send_header(16'hFFFF);
		send_byte(CH_OPEN);
		send_byte(8'd3);
		send_byte(8'd0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_OPEN);
		send_read_at(8'd0);
		send_read_at(8'd2);
		send_byte(CH_OPEN);
		send_tick();
		send_restart();
		framed_traffic(60);
		leave_partial();
		settle();

		write_regs(1'b0, 16'd1);
		send_byte(CH_OPEN);
		send_tick();
		framed_traffic(45);
		leave_partial();
		settle();

		write_regs(1'b0, 16'd3);
		send_header(16'(MAX_PAYLOAD));
		send_restart();
		framed_traffic(60);
		leave_partial();
		settle();

		write_regs(1'b1, 16'hFFFF);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_line(MAX_PAYLOAD + 1, 1'b0, 1'b0);
		send_read_at(8'hFF);
		send_byte(CH_LF);
		line_traffic(60);
		leave_partial();
		settle();

		write_regs(1'b0, 16'd0);
		send_byte(CH_OPEN);
		send_tick();
		framed_traffic(35);
		leave_partial();
		settle();

		write_regs(1'b1, TIMEOUT_RESET);
		line_traffic(40);
		leave_partial();
		settle();

		write_regs(1'b0, 16'hFFFF);
		framed_traffic(40);
		settle();

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== length_prefixed_frame_receiver.f =====
+incdir+src
src/lpfr_pkg.sv
src/lpfr_if.sv
src/lpfr_ram.sv
src/length_prefixed_frame_receiver.sv
bench/tb_length_prefixed_frame_receiver.sv
